FILE: hdl/bmsi_pkg.sv
package bmsi_pkg;

    localparam int WORK_RAM_BYTES = 1024;
    localparam int WRAM_AW        = $clog2(WORK_RAM_BYTES);
    localparam int WRAM_HALF_BIT  = WRAM_AW - 1;

    localparam int              A12_FILTER_W       = 4;
    localparam logic [A12_FILTER_W-1:0] A12_FILTER_FETCHES = A12_FILTER_W'(8);

    localparam int PRG_BANK_W = 6;
    localparam logic [7:0] PRG_FIXED_LO  = 8'h3E;
    localparam logic [7:0] PRG_FIXED_HI  = 8'h3F;
    localparam logic [7:0] CHR_PAIR_MASK = 8'hFE;
    localparam logic [7:0] PRG_NUM_MASK  = 8'h3F;

    localparam int CMD_RAM_ON_BIT   = 5;
    localparam int CMD_PRG_SWAP_BIT = 6;
    localparam int CMD_CHR_INV_BIT  = 7;

    localparam int EN_LO_WRITE_BIT = 4;
    localparam int EN_LO_READ_BIT  = 5;
    localparam int EN_HI_WRITE_BIT = 6;
    localparam int EN_HI_READ_BIT  = 7;

    localparam logic [7:0] PRG_CFG_MASK_RST = 8'd63;
    localparam logic [7:0] CHR_CFG_MASK_RST = 8'd255;

    typedef enum logic [1:0] {
        ACT_CPU_READ  = 2'd0,
        ACT_CPU_WRITE = 2'd1,
        ACT_PPU_FETCH = 2'd2
    } t_action;

    typedef enum logic [1:0] {
        CFG_PRG_MASK = 2'd0,
        CFG_PRG_BASE = 2'd1,
        CFG_CHR_MASK = 2'd2,
        CFG_CHR_BASE = 2'd3
    } t_cfg_index;

    typedef enum logic [1:0] {
        SEL_BANK      = 2'd0,
        SEL_MIRROR    = 2'd1,
        SEL_IRQ_LATCH = 2'd2,
        SEL_IRQ_CTRL  = 2'd3
    } t_reg_sel;

    typedef enum logic [2:0] {
        TGT_CHR_PAIR0 = 3'd0,
        TGT_CHR_PAIR1 = 3'd1,
        TGT_CHR4      = 3'd2,
        TGT_CHR5      = 3'd3,
        TGT_CHR6      = 3'd4,
        TGT_CHR7      = 3'd5,
        TGT_PRG0      = 3'd6,
        TGT_PRG1      = 3'd7
    } t_bank_target;

    typedef struct packed {
        logic               we;
        logic               re;
        logic [WRAM_AW-1:0] addr;
        logic [7:0]         wdata;
    } t_ram_req;

    typedef struct packed {
        logic       rd_ram;
        logic       drv;
        logic [7:0] bank;
        logic       bv;
        logic       mirror;
        logic       irq;
    } t_meta;

endpackage

FILE: hdl/bank_mapper_with_scanline_irq_core.sv
// Cartridge bank mapper with work RAM and scanline interrupt counter. One bus
// access (CPU read, CPU write or PPU fetch) is taken per beat, one beat per
// cycle sustained unless i_out_ready stalls the output, and each gives exactly
// one result beat, held in the stage-one and then the output register; the
// 1 KiB work RAM has a registered read port. Bank, mirroring and irq fields
// show the mapper state after the access is applied. Configuration writes
// (masks and bases) take effect at once and belong while no beat is in flight.
module bank_mapper_with_scanline_irq_core (
    input  logic        i_clk,
    input  logic        i_rst_n,

    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_index,
    input  logic [7:0]  i_cfg_data,

    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [1:0]  i_action,
    input  logic [15:0] i_address,
    input  logic [7:0]  i_write_data,

    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [7:0]  o_read_data,
    output logic        o_data_driven,
    output logic [7:0]  o_bank_number,
    output logic        o_bank_valid,
    output logic        o_mirror_horizontal,
    output logic        o_irq_line
);

    localparam int PBW = bmsi_pkg::PRG_BANK_W;
    localparam int FW  = bmsi_pkg::A12_FILTER_W;

    logic [7:0]    r_prg_mask, r_prg_base, r_chr_mask, r_chr_base;
    logic [7:0]    r_command, n_command;
    logic [PBW-1:0] r_prg_bank [2];
    logic [PBW-1:0] n_prg_bank [2];
    logic [7:0]    r_chr_bank [8];
    logic [7:0]    n_chr_bank [8];
    logic [7:0]    r_ram_en, n_ram_en;
    logic          r_mirror, n_mirror;
    logic [7:0]    r_irq_reload, n_irq_reload;
    logic [7:0]    r_irq_count, n_irq_count;
    logic          r_irq_armed, n_irq_armed;
    logic          r_irq_pending, n_irq_pending;
    logic [FW-1:0] r_a12_filter, n_a12_filter;

    logic          r_s1_valid;
    bmsi_pkg::t_meta r_s1, n_s1;
    logic          r_out_valid;
    logic [7:0]    r_out_read_data;
    bmsi_pkg::t_meta r_out;

    bmsi_pkg::t_ram_req ram_req;
    logic [7:0]    ram_rdata;

    logic          in_acc;
    logic          s1_go;
    logic          in_wram;
    logic          upper;
    logic          odd;
    logic          a12_high;
    logic [FW-1:0] filt_dec;
    logic [2:0]    chr_slot;

    function automatic logic [7:0] prg_slot_bank(
        input logic [1:0]     slot,
        input logic [7:0]     cmd,
        input logic [PBW-1:0] bank0,
        input logic [PBW-1:0] bank1,
        input logic [7:0]     mask,
        input logic [7:0]     base
    );
        logic [1:0] s;
        logic [7:0] b;
        s = slot;
        if (!s[0] && cmd[bmsi_pkg::CMD_PRG_SWAP_BIT]) begin
            s = s ^ 2'b10;
        end
        unique case (s)
            2'd0:    b = 8'(bank0);
            2'd1:    b = 8'(bank1);
            2'd2:    b = bmsi_pkg::PRG_FIXED_LO;
            default: b = bmsi_pkg::PRG_FIXED_HI;
        endcase
        return (b & mask) | base;
    endfunction

    bmsi_wram u_wram (
        .i_clk   (i_clk),
        .i_req   (ram_req),
        .o_rdata (ram_rdata)
    );

    assign s1_go      = r_s1_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready = !r_s1_valid || !r_out_valid || i_out_ready;
    assign in_acc     = i_in_valid && o_in_ready;

    assign in_wram  = (i_address[15:12] == 4'h7);
    assign upper    = i_address[bmsi_pkg::WRAM_HALF_BIT];
    assign odd      = i_address[0];
    assign a12_high = i_address[12];
    assign filt_dec = (r_a12_filter != '0) ? r_a12_filter - FW'(1) : '0;
    assign chr_slot = i_address[12:10] ^ {r_command[bmsi_pkg::CMD_CHR_INV_BIT], 2'b00};

    always_comb begin
        logic [7:0] cnt;
        cnt           = '0;
        n_command     = r_command;
        n_prg_bank    = r_prg_bank;
        n_chr_bank    = r_chr_bank;
        n_ram_en      = r_ram_en;
        n_mirror      = r_mirror;
        n_irq_reload  = r_irq_reload;
        n_irq_count   = r_irq_count;
        n_irq_armed   = r_irq_armed;
        n_irq_pending = r_irq_pending;
        n_a12_filter  = r_a12_filter;
        ram_req       = '0;
        ram_req.addr  = i_address[bmsi_pkg::WRAM_AW-1:0];
        ram_req.wdata = i_write_data;
        n_s1          = '0;

        if (in_acc) begin
            unique case (bmsi_pkg::t_action'(i_action))
                bmsi_pkg::ACT_CPU_READ: begin
                    if (in_wram) begin
                        n_s1.drv    = r_ram_en[bmsi_pkg::EN_LO_READ_BIT]
                                    | r_ram_en[bmsi_pkg::EN_HI_READ_BIT];
                        n_s1.rd_ram = upper ? r_ram_en[bmsi_pkg::EN_HI_READ_BIT]
                                            : r_ram_en[bmsi_pkg::EN_LO_READ_BIT];
                        ram_req.re  = n_s1.rd_ram;
                    end else if (i_address[15]) begin
                        n_s1.bank = prg_slot_bank(i_address[14:13], r_command,
                            r_prg_bank[0], r_prg_bank[1], r_prg_mask, r_prg_base);
                        n_s1.bv   = 1'b1;
                    end
                end
                bmsi_pkg::ACT_CPU_WRITE: begin
                    if (in_wram) begin
                        ram_req.we = upper
                            ? (r_ram_en[bmsi_pkg::EN_HI_READ_BIT]
                               && r_ram_en[bmsi_pkg::EN_HI_WRITE_BIT])
                            : (r_ram_en[bmsi_pkg::EN_LO_READ_BIT]
                               && r_ram_en[bmsi_pkg::EN_LO_WRITE_BIT]);
                    end else if (i_address[15]) begin
                        unique case (bmsi_pkg::t_reg_sel'(i_address[14:13]))
                            bmsi_pkg::SEL_BANK: begin
                                if (odd) begin
                                    unique case (bmsi_pkg::t_bank_target'(r_command[2:0]))
                                        bmsi_pkg::TGT_CHR_PAIR0: begin
                                            n_chr_bank[0] = i_write_data
                                                          & bmsi_pkg::CHR_PAIR_MASK;
                                            n_chr_bank[1] = (i_write_data
                                                          & bmsi_pkg::CHR_PAIR_MASK) | 8'd1;
                                        end
                                        bmsi_pkg::TGT_CHR_PAIR1: begin
                                            n_chr_bank[2] = i_write_data
                                                          & bmsi_pkg::CHR_PAIR_MASK;
                                            n_chr_bank[3] = (i_write_data
                                                          & bmsi_pkg::CHR_PAIR_MASK) | 8'd1;
                                        end
                                        bmsi_pkg::TGT_CHR4: n_chr_bank[4] = i_write_data;
                                        bmsi_pkg::TGT_CHR5: n_chr_bank[5] = i_write_data;
                                        bmsi_pkg::TGT_CHR6: n_chr_bank[6] = i_write_data;
                                        bmsi_pkg::TGT_CHR7: n_chr_bank[7] = i_write_data;
                                        bmsi_pkg::TGT_PRG0: n_prg_bank[0] = PBW'(i_write_data
                                                          & bmsi_pkg::PRG_NUM_MASK);
                                        default:            n_prg_bank[1] = PBW'(i_write_data
                                                          & bmsi_pkg::PRG_NUM_MASK);
                                    endcase
                                end else begin
                                    n_command = i_write_data;
                                    if (!i_write_data[bmsi_pkg::CMD_RAM_ON_BIT]) begin
                                        n_ram_en = '0;
                                    end
                                end
                            end
                            bmsi_pkg::SEL_MIRROR: begin
                                if (odd) begin
                                    if (r_command[bmsi_pkg::CMD_RAM_ON_BIT]) begin
                                        n_ram_en = i_write_data;
                                    end
                                end else begin
                                    n_mirror = i_write_data[0];
                                end
                            end
                            bmsi_pkg::SEL_IRQ_LATCH: begin
                                if (odd) begin
                                    n_irq_count = '0;
                                end else begin
                                    n_irq_reload = i_write_data;
                                end
                            end
                            default: begin
                                n_irq_armed = odd;
                                if (!odd) begin
                                    n_irq_pending = 1'b0;
                                end
                            end
                        endcase
                        n_s1.bank = prg_slot_bank(i_address[14:13], n_command,
                            n_prg_bank[0], n_prg_bank[1], r_prg_mask, r_prg_base);
                        n_s1.bv   = 1'b1;
                    end
                end
                bmsi_pkg::ACT_PPU_FETCH: begin
                    n_a12_filter = filt_dec;
                    if (filt_dec == '0 && a12_high) begin
                        cnt = (r_irq_count == '0) ? r_irq_reload : r_irq_count - 8'd1;
                        n_irq_count = cnt;
                        if (cnt == '0 && r_irq_armed) begin
                            n_irq_pending = 1'b1;
                        end
                    end
                    if (a12_high) begin
                        n_a12_filter = bmsi_pkg::A12_FILTER_FETCHES;
                    end
                    if (!i_address[13]) begin
                        n_s1.bank = (r_chr_bank[chr_slot] & r_chr_mask) | r_chr_base;
                        n_s1.bv   = 1'b1;
                    end
                end
                default: begin
                end
            endcase
        end

        n_s1.mirror = n_mirror;
        n_s1.irq    = n_irq_pending;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prg_mask    <= bmsi_pkg::PRG_CFG_MASK_RST;
            r_prg_base    <= '0;
            r_chr_mask    <= bmsi_pkg::CHR_CFG_MASK_RST;
            r_chr_base    <= '0;
            r_command     <= '0;
            r_prg_bank[0] <= PBW'(0);
            r_prg_bank[1] <= PBW'(1);
            for (int i = 0; i < 8; i++) begin
                r_chr_bank[i] <= 8'(i);
            end
            r_ram_en      <= '0;
            r_mirror      <= 1'b0;
            r_irq_reload  <= '0;
            r_irq_count   <= '0;
            r_irq_armed   <= 1'b0;
            r_irq_pending <= 1'b0;
            r_a12_filter  <= '0;
            r_s1_valid    <= 1'b0;
            r_out_valid   <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                unique case (bmsi_pkg::t_cfg_index'(i_cfg_index))
                    bmsi_pkg::CFG_PRG_MASK: r_prg_mask <= i_cfg_data;
                    bmsi_pkg::CFG_PRG_BASE: r_prg_base <= i_cfg_data;
                    bmsi_pkg::CFG_CHR_MASK: r_chr_mask <= i_cfg_data;
                    default:                r_chr_base <= i_cfg_data;
                endcase
            end
            r_command     <= n_command;
            r_prg_bank    <= n_prg_bank;
            r_chr_bank    <= n_chr_bank;
            r_ram_en      <= n_ram_en;
            r_mirror      <= n_mirror;
            r_irq_reload  <= n_irq_reload;
            r_irq_count   <= n_irq_count;
            r_irq_armed   <= n_irq_armed;
            r_irq_pending <= n_irq_pending;
            r_a12_filter  <= n_a12_filter;

            if (in_acc) begin
                r_s1_valid <= 1'b1;
            end else if (s1_go) begin
                r_s1_valid <= 1'b0;
            end

            if (s1_go) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // result payload, no reset needed
    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_s1 <= n_s1;
        end
        if (s1_go) begin
            r_out           <= r_s1;
            r_out_read_data <= r_s1.rd_ram ? ram_rdata : 8'd0;
        end
    end

    assign o_out_valid         = r_out_valid;
    assign o_read_data         = r_out_read_data;
    assign o_data_driven       = r_out.drv;
    assign o_bank_number       = r_out.bank;
    assign o_bank_valid        = r_out.bv;
    assign o_mirror_horizontal = r_out.mirror;
    assign o_irq_line          = r_out.irq;

    a_irq_rise_on_fetch: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_irq_pending) |->
            $past(in_acc && i_action == bmsi_pkg::ACT_PPU_FETCH))
        else $error("irq raised without a ppu fetch beat");

    a_filter_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_a12_filter <= bmsi_pkg::A12_FILTER_FETCHES)
        else $error("a12 filter out of range");

    a_stall_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_in_ready |-> (r_s1_valid && r_out_valid && !i_out_ready))
        else $error("input stalled with room in the pipe");

    a_accept_fills: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc |=> r_s1_valid)
        else $error("accepted beat lost before stage one");

    a_ram_port_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ram_req.we |-> (!ram_req.re && in_acc && i_action == bmsi_pkg::ACT_CPU_WRITE))
        else $error("work ram write outside a cpu write beat");

endmodule

FILE: hdl/bmsi_wram.sv
module bmsi_wram (
    input  logic                       i_clk,
    input  bmsi_pkg::t_ram_req         i_req,
    output logic [7:0]                 o_rdata
);

    logic [7:0] r_mem [bmsi_pkg::WORK_RAM_BYTES];
    logic [7:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_req.we) begin
            r_mem[i_req.addr] <= i_req.wdata;
        end
        if (i_req.re) begin
            r_rdata <= r_mem[i_req.addr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

FILE: verif/mapper_result_checker.sv
`timescale 1ns / 1ps

module mapper_result_checker
    import bmsi_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,

    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_index,
    input  logic [7:0]  i_cfg_data,

    input  logic        i_in_valid,
    input  logic        i_in_ready,
    input  logic [1:0]  i_action,
    input  logic [15:0] i_address,
    input  logic [7:0]  i_write_data,

    input  logic        i_out_valid,
    input  logic        i_out_ready,
    input  logic [7:0]  i_read_data,
    input  logic        i_data_driven,
    input  logic [7:0]  i_bank_number,
    input  logic        i_bank_valid,
    input  logic        i_mirror_horizontal,
    input  logic        i_irq_line,

    output int          o_fail_count,
    output int          o_outstanding,
    output int          o_results_checked,
    output int          o_irq_results
);

    typedef struct packed {
        logic [7:0] read_data;
        logic       data_driven;
        logic [7:0] bank_number;
        logic       bank_valid;
        logic       mirror_horizontal;
        logic       irq_line;
    } t_access_result;

    logic [7:0]              cfg_prg_mask;
    logic [7:0]              cfg_prg_base;
    logic [7:0]              cfg_chr_mask;
    logic [7:0]              cfg_chr_base;
    logic [7:0]              command;
    logic [PRG_BANK_W-1:0]   prg_bank [2];
    logic [7:0]              chr_bank [8];
    logic [7:0]              ram_enable;
    logic                    mirror;
    logic [7:0]              irq_latch;
    logic [7:0]              irq_counter;
    logic                    irq_armed;
    logic                    irq_pending;
    logic [A12_FILTER_W-1:0] a12_filter;
    logic [7:0]              wram [WORK_RAM_BYTES];

    t_access_result expected_results[$];
    int fail_tally  = 0;
    int n_predicted = 0;
    int n_checked   = 0;
    int n_irq       = 0;

    assign o_fail_count      = fail_tally;
    assign o_outstanding     = n_predicted - n_checked;
    assign o_results_checked = n_checked;
    assign o_irq_results     = n_irq;

    task automatic reset_state();
        cfg_prg_mask = PRG_CFG_MASK_RST;
        cfg_prg_base = '0;
        cfg_chr_mask = CHR_CFG_MASK_RST;
        cfg_chr_base = '0;
        command      = '0;
        prg_bank[0]  = PRG_BANK_W'(0);
        prg_bank[1]  = PRG_BANK_W'(1);
        for (int k = 0; k < 8; k++) begin
            chr_bank[k] = 8'(k);
        end
        ram_enable  = '0;
        mirror      = 1'b0;
        irq_latch   = '0;
        irq_counter = '0;
        irq_armed   = 1'b0;
        irq_pending = 1'b0;
        a12_filter  = '0;
    endtask

    function automatic logic [7:0] prg_window_bank(input logic [1:0] slot);
        logic [1:0] s;
        logic [7:0] b;
        s = slot;
        b = '0;
        if (!s[0] && command[CMD_PRG_SWAP_BIT]) s[1] = ~s[1];
        case (s)
            2'd0: b[PRG_BANK_W-1:0] = prg_bank[0];
            2'd1: b[PRG_BANK_W-1:0] = prg_bank[1];
            2'd2: b = PRG_FIXED_LO;
            default: b = PRG_FIXED_HI;
        endcase
        return (b & cfg_prg_mask) | cfg_prg_base;
    endfunction

    function automatic logic [7:0] chr_window_bank(input logic [2:0] slot);
        logic [2:0] s;
        s = slot ^ {command[CMD_CHR_INV_BIT], 2'b00};
        return (chr_bank[s] & cfg_chr_mask) | cfg_chr_base;
    endfunction

    task automatic write_mapper_reg(input logic [15:0] a, input logic [7:0] v);
        case (t_reg_sel'(a[14:13]))
            SEL_BANK: begin
                if (a[0]) begin
                    case (t_bank_target'(command[2:0]))
                        TGT_CHR_PAIR0: begin
                            chr_bank[0] = v & CHR_PAIR_MASK;
                            chr_bank[1] = (v & CHR_PAIR_MASK) | 8'h01;
                        end
                        TGT_CHR_PAIR1: begin
                            chr_bank[2] = v & CHR_PAIR_MASK;
                            chr_bank[3] = (v & CHR_PAIR_MASK) | 8'h01;
                        end
                        TGT_CHR4: chr_bank[4] = v;
                        TGT_CHR5: chr_bank[5] = v;
                        TGT_CHR6: chr_bank[6] = v;
                        TGT_CHR7: chr_bank[7] = v;
                        TGT_PRG0: prg_bank[0] = v[PRG_BANK_W-1:0];
                        default:  prg_bank[1] = v[PRG_BANK_W-1:0];
                    endcase
                end else begin
                    command = v;
                    if (!v[CMD_RAM_ON_BIT]) ram_enable = '0;
                end
            end
            SEL_MIRROR: begin
                if (a[0]) begin
                    if (command[CMD_RAM_ON_BIT]) ram_enable = v;
                end else begin
                    mirror = v[0];
                end
            end
            SEL_IRQ_LATCH: begin
                if (a[0]) irq_counter = '0;
                else irq_latch = v;
            end
            default: begin
                irq_armed = a[0];
                if (!a[0]) irq_pending = 1'b0;
            end
        endcase
    endtask

    // a12 rise after a long enough low stretch clocks the scanline counter
    task automatic clock_scanline(input logic a12);
        if (a12_filter != 0) a12_filter = a12_filter - 1'b1;
        if (a12_filter == 0 && a12) begin
            if (irq_counter == 0) irq_counter = irq_latch;
            else irq_counter = irq_counter - 1'b1;
            if (irq_counter == 0 && irq_armed) irq_pending = 1'b1;
        end
        if (a12) a12_filter = A12_FILTER_FETCHES;
    endtask

    task automatic apply_bus_access(input logic [1:0] act, input logic [15:0] a,
                                    input logic [7:0] d, output t_access_result r);
        logic upper;
        upper = a[WRAM_HALF_BIT];
        r = '0;
        case (act)
            ACT_CPU_READ: begin
                if (a[15:12] == 4'h7) begin
                    if (ram_enable[EN_HI_READ_BIT] || ram_enable[EN_LO_READ_BIT]) begin
                        r.data_driven = 1'b1;
                        if (ram_enable[upper ? EN_HI_READ_BIT : EN_LO_READ_BIT])
                            r.read_data = wram[a[WRAM_AW-1:0]];
                    end
                end else if (a[15]) begin
                    r.bank_number = prg_window_bank(a[14:13]);
                    r.bank_valid  = 1'b1;
                end
            end
            ACT_CPU_WRITE: begin
                if (a[15:12] == 4'h7) begin
                    if (upper ? (ram_enable[EN_HI_READ_BIT] && ram_enable[EN_HI_WRITE_BIT])
                              : (ram_enable[EN_LO_READ_BIT] && ram_enable[EN_LO_WRITE_BIT]))
                        wram[a[WRAM_AW-1:0]] = d;
                end else if (a[15]) begin
                    write_mapper_reg(a, d);
                    r.bank_number = prg_window_bank(a[14:13]);
                    r.bank_valid  = 1'b1;
                end
            end
            ACT_PPU_FETCH: begin
                clock_scanline(a[12]);
                if (!a[13]) begin
                    r.bank_number = chr_window_bank(a[12:10]);
                    r.bank_valid  = 1'b1;
                end
            end
            default: ;
        endcase
        r.mirror_horizontal = mirror;
        r.irq_line          = irq_pending;
    endtask

    task automatic check_field(input string name, input logic [7:0] want,
                               input logic [7:0] got);
        if (got !== want) begin
            $display("%0t mismatch on %s: expected %h, actual %h", $time, name, want, got);
            fail_tally++;
        end
    endtask

    always @(posedge i_clk) begin : watch
        t_access_result want;
        t_access_result got;
        if (!i_rst_n) begin
            reset_state();
            expected_results.delete();
        end else begin
            if (i_cfg_we) begin
                case (t_cfg_index'(i_cfg_index))
                    CFG_PRG_MASK: cfg_prg_mask = i_cfg_data;
                    CFG_PRG_BASE: cfg_prg_base = i_cfg_data;
                    CFG_CHR_MASK: cfg_chr_mask = i_cfg_data;
                    default:      cfg_chr_base = i_cfg_data;
                endcase
            end
            if (i_in_valid && i_in_ready) begin
                apply_bus_access(i_action, i_address, i_write_data, want);
                expected_results.push_back(want);
                n_predicted <= n_predicted + 1;
            end
            if (i_out_valid && i_out_ready) begin
                got.read_data         = i_read_data;
                got.data_driven       = i_data_driven;
                got.bank_number       = i_bank_number;
                got.bank_valid        = i_bank_valid;
                got.mirror_horizontal = i_mirror_horizontal;
                got.irq_line          = i_irq_line;
                n_checked <= n_checked + 1;
                if (got.irq_line) n_irq <= n_irq + 1;
                if (expected_results.size() == 0) begin
                    $display("%0t result beat with nothing expected: expected none, actual %h",
                             $time, got);
                    fail_tally++;
                end else begin
                    want = expected_results.pop_front();
                    check_field("read_data", want.read_data, got.read_data);
                    check_field("data_driven", want.data_driven, got.data_driven);
                    check_field("bank_number", want.bank_number, got.bank_number);
                    check_field("bank_valid", want.bank_valid, got.bank_valid);
                    check_field("mirror_horizontal", want.mirror_horizontal,
                                got.mirror_horizontal);
                    check_field("irq_line", want.irq_line, got.irq_line);
                end
            end
        end
    end

endmodule

FILE: verif/tb_bank_mapper_with_scanline_irq_core.sv
`timescale 1ns / 1ps

module tb_bank_mapper_with_scanline_irq_core;

    localparam logic [1:0] ACT_UNUSED  = 2'd3;
    localparam int         CYCLE_LIMIT = 200000;
    localparam int         IDLE_PCT    = 32;

    logic        i_clk        = 1'b0;
    logic        i_rst_n      = 1'b0;
    logic        i_cfg_we     = 1'b0;
    logic [1:0]  i_cfg_index  = '0;
    logic [7:0]  i_cfg_data   = '0;
    logic        i_in_valid   = 1'b0;
    logic        o_in_ready;
    logic [1:0]  i_action     = '0;
    logic [15:0] i_address    = '0;
    logic [7:0]  i_write_data = '0;
    logic        o_out_valid;
    logic        i_out_ready  = 1'b0;
    logic [7:0]  o_read_data;
    logic        o_data_driven;
    logic [7:0]  o_bank_number;
    logic        o_bank_valid;
    logic        o_mirror_horizontal;
    logic        o_irq_line;

    int fail_count;
    int outstanding;
    int results_checked;
    int irq_results;

    logic steady = 1'b0;
    int   cycles = 0;
    int   items_sent = 0;
    int   n_by_action [4];

    // what the stimulus knows of the work ram gating, to avoid unwritten reads
    bit       ram_on_shadow;
    bit [7:0] ram_en_shadow;
    bit       ram_written [bmsi_pkg::WORK_RAM_BYTES];

    bank_mapper_with_scanline_irq_core uut (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_cfg_we            (i_cfg_we),
        .i_cfg_index         (i_cfg_index),
        .i_cfg_data          (i_cfg_data),
        .i_in_valid          (i_in_valid),
        .o_in_ready          (o_in_ready),
        .i_action            (i_action),
        .i_address           (i_address),
        .i_write_data        (i_write_data),
        .o_out_valid         (o_out_valid),
        .i_out_ready         (i_out_ready),
        .o_read_data         (o_read_data),
        .o_data_driven       (o_data_driven),
        .o_bank_number       (o_bank_number),
        .o_bank_valid        (o_bank_valid),
        .o_mirror_horizontal (o_mirror_horizontal),
        .o_irq_line          (o_irq_line)
    );

    mapper_result_checker u_result_check (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_cfg_we            (i_cfg_we),
        .i_cfg_index         (i_cfg_index),
        .i_cfg_data          (i_cfg_data),
        .i_in_valid          (i_in_valid),
        .i_in_ready          (o_in_ready),
        .i_action            (i_action),
        .i_address           (i_address),
        .i_write_data        (i_write_data),
        .i_out_valid         (o_out_valid),
        .i_out_ready         (i_out_ready),
        .i_read_data         (o_read_data),
        .i_data_driven       (o_data_driven),
        .i_bank_number       (o_bank_number),
        .i_bank_valid        (o_bank_valid),
        .i_mirror_horizontal (o_mirror_horizontal),
        .i_irq_line          (o_irq_line),
        .o_fail_count        (fail_count),
        .o_outstanding       (outstanding),
        .o_results_checked   (results_checked),
        .o_irq_results       (irq_results)
    );

    always #5 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        i_out_ready <= steady || ($urandom_range(99, 0) >= IDLE_PCT);
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("FAIL bank_mapper_with_scanline_irq_core");
            $finish;
        end
    end

    function automatic logic [7:0] pick_byte();
        case ($urandom_range(7, 0))
            0: return 8'h00;
            1: return 8'hFF;
            default: return 8'($urandom);
        endcase
    endfunction

    function automatic logic [15:0] ram_addr();
        logic [15:0] a;
        a = 16'h7000 | 16'($urandom_range(12'hFFF, 0));
        // most traffic lands on a small set of entries so reads find data
        if ($urandom_range(3, 0) != 0) a = a & 16'hFE1F;
        return a;
    endfunction

    task automatic send_access(input logic [1:0] act, input logic [15:0] a,
                               input logic [7:0] d);
        logic [1:0] kind;
        logic       hi;
        kind = act;
        hi   = a[bmsi_pkg::WRAM_HALF_BIT];
        if (kind == bmsi_pkg::ACT_CPU_READ && a[15:12] == 4'h7
            && !ram_written[a[bmsi_pkg::WRAM_AW-1:0]]
            && ram_en_shadow[hi ? bmsi_pkg::EN_HI_READ_BIT : bmsi_pkg::EN_LO_READ_BIT])
            kind = bmsi_pkg::ACT_CPU_WRITE;
        if (kind == bmsi_pkg::ACT_CPU_WRITE && a[15:12] == 4'h7) begin
            if (hi ? (ram_en_shadow[bmsi_pkg::EN_HI_READ_BIT]
                      && ram_en_shadow[bmsi_pkg::EN_HI_WRITE_BIT])
                   : (ram_en_shadow[bmsi_pkg::EN_LO_READ_BIT]
                      && ram_en_shadow[bmsi_pkg::EN_LO_WRITE_BIT]))
                ram_written[a[bmsi_pkg::WRAM_AW-1:0]] = 1'b1;
        end else if (kind == bmsi_pkg::ACT_CPU_WRITE && a[15]) begin
            if (bmsi_pkg::t_reg_sel'(a[14:13]) == bmsi_pkg::SEL_BANK && !a[0]) begin
                ram_on_shadow = d[bmsi_pkg::CMD_RAM_ON_BIT];
                if (!d[bmsi_pkg::CMD_RAM_ON_BIT]) ram_en_shadow = '0;
            end else if (bmsi_pkg::t_reg_sel'(a[14:13]) == bmsi_pkg::SEL_MIRROR && a[0]
                         && ram_on_shadow) begin
                ram_en_shadow = d;
            end
        end
        while (!steady && $urandom_range(99, 0) < IDLE_PCT) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid   <= 1'b1;
        i_action     <= kind;
        i_address    <= a;
        i_write_data <= d;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        n_by_action[kind]++;
        items_sent++;
    endtask

    task automatic drain_results();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (outstanding != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_cfg(input bmsi_pkg::t_cfg_index idx, input logic [7:0] v);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= v;
        @(posedge i_clk);
    endtask

    task automatic program_windows(input logic [7:0] pm, input logic [7:0] pb,
                                   input logic [7:0] cm, input logic [7:0] cb);
        drain_results();
        write_cfg(bmsi_pkg::CFG_PRG_MASK, pm);
        write_cfg(bmsi_pkg::CFG_PRG_BASE, pb);
        write_cfg(bmsi_pkg::CFG_CHR_MASK, cm);
        write_cfg(bmsi_pkg::CFG_CHR_BASE, cb);
        i_cfg_we <= 1'b0;
    endtask

    task automatic run_random(input int count);
        int         stop_at;
        int         n;
        logic [1:0] act;
        stop_at = items_sent + count;
        while (items_sent < stop_at) begin
            case ($urandom_range(9, 0))
                0: begin
                    send_access(bmsi_pkg::ACT_CPU_WRITE,
                                {1'b1, bmsi_pkg::SEL_BANK, 12'($urandom), 1'b0},
                                pick_byte());
                    send_access(bmsi_pkg::ACT_CPU_WRITE,
                                {1'b1, bmsi_pkg::SEL_BANK, 12'($urandom), 1'b1},
                                pick_byte());
                end
                1: send_access(bmsi_pkg::ACT_CPU_WRITE, 16'h8000 | 16'($urandom),
                               pick_byte());
                2, 3: begin
                    if ($urandom_range(1, 0) != 0) begin
                        send_access(bmsi_pkg::ACT_CPU_WRITE,
                                    {1'b1, bmsi_pkg::SEL_BANK, 12'($urandom), 1'b0},
                                    pick_byte() | 8'h20);
                        send_access(bmsi_pkg::ACT_CPU_WRITE,
                                    {1'b1, bmsi_pkg::SEL_MIRROR, 12'($urandom), 1'b1},
                                    ($urandom_range(1, 0) != 0) ? 8'hF0 : pick_byte());
                    end
                    n = $urandom_range(8, 2);
                    repeat (n) begin
                        act = ($urandom_range(1, 0) != 0) ? bmsi_pkg::ACT_CPU_READ
                                                          : bmsi_pkg::ACT_CPU_WRITE;
                        send_access(act, ram_addr(), pick_byte());
                    end
                end
                4, 5, 6: begin
                    // scanline: a run of a12-low fetches, then a few a12-high ones
                    n = $urandom_range(12, 4);
                    repeat (n) send_access(bmsi_pkg::ACT_PPU_FETCH,
                                           {3'($urandom), 1'b0, 12'($urandom)}, pick_byte());
                    n = $urandom_range(3, 1);
                    repeat (n) send_access(bmsi_pkg::ACT_PPU_FETCH,
                                           {3'($urandom), 1'b1, 12'($urandom)}, pick_byte());
                end
                7: begin
                    n = $urandom_range(4, 1);
                    repeat (n) send_access(bmsi_pkg::ACT_CPU_READ, 16'h8000 | 16'($urandom),
                                           pick_byte());
                end
                8: begin
                    case ($urandom_range(2, 0))
                        0: send_access(bmsi_pkg::ACT_CPU_WRITE,
                                       {1'b1, bmsi_pkg::SEL_IRQ_LATCH, 12'($urandom), 1'b0},
                                       8'($urandom_range(6, 0)));
                        1: send_access(bmsi_pkg::ACT_CPU_WRITE,
                                       {1'b1, bmsi_pkg::SEL_IRQ_LATCH, 12'($urandom), 1'b1},
                                       pick_byte());
                        default: send_access(bmsi_pkg::ACT_CPU_WRITE,
                                             {1'b1, bmsi_pkg::SEL_IRQ_CTRL, 13'($urandom)},
                                             pick_byte());
                    endcase
                end
                default: send_access(2'($urandom), 16'($urandom), pick_byte());
            endcase
        end
    endtask

    initial begin
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        program_windows(bmsi_pkg::PRG_CFG_MASK_RST, 8'h00,
                        bmsi_pkg::CHR_CFG_MASK_RST, 8'h00);
        send_access(bmsi_pkg::ACT_CPU_READ,  16'h7123, 8'h00);
        send_access(bmsi_pkg::ACT_CPU_READ,  16'h0000, 8'h00);
        send_access(bmsi_pkg::ACT_CPU_WRITE, 16'h6FFF, 8'hFF);
        send_access(bmsi_pkg::ACT_CPU_READ,  16'h8000, 8'h00);
        send_access(bmsi_pkg::ACT_CPU_READ,  16'hFFFF, 8'h00);
        send_access(bmsi_pkg::ACT_CPU_WRITE, 16'h8000, 8'hE6);
        send_access(bmsi_pkg::ACT_CPU_WRITE, 16'h8001, 8'hFF);
        send_access(bmsi_pkg::ACT_CPU_READ,  16'hC000, 8'h00);
        send_access(bmsi_pkg::ACT_CPU_WRITE, 16'hA001, 8'hF0);
        send_access(bmsi_pkg::ACT_CPU_WRITE, 16'h7000, 8'hA5);
        send_access(bmsi_pkg::ACT_CPU_WRITE, 16'h73FF, 8'h5A);
        send_access(bmsi_pkg::ACT_CPU_READ,  16'h7000, 8'h00);
        send_access(bmsi_pkg::ACT_CPU_READ,  16'h7FFF, 8'h00);
        send_access(bmsi_pkg::ACT_CPU_WRITE, 16'hA001, 8'h20);
        send_access(bmsi_pkg::ACT_CPU_READ,  16'h7200, 8'h00);
        send_access(bmsi_pkg::ACT_CPU_WRITE, 16'h8000, 8'h00);
        send_access(bmsi_pkg::ACT_CPU_WRITE, 16'hA001, 8'hFF);
        send_access(bmsi_pkg::ACT_CPU_READ,  16'h7000, 8'h00);
        send_access(bmsi_pkg::ACT_CPU_WRITE, 16'hA000, 8'h01);
        send_access(bmsi_pkg::ACT_CPU_WRITE, 16'hC000, 8'h00);
        send_access(bmsi_pkg::ACT_CPU_WRITE, 16'hC001, 8'h00);
        send_access(bmsi_pkg::ACT_CPU_WRITE, 16'hE001, 8'h00);
        send_access(bmsi_pkg::ACT_PPU_FETCH, 16'h0000, 8'h00);
        send_access(bmsi_pkg::ACT_PPU_FETCH, 16'h1FFF, 8'h00);
        send_access(bmsi_pkg::ACT_PPU_FETCH, 16'hEC00, 8'h00);
        send_access(ACT_UNUSED,              16'hFFFF, 8'hFF);
        send_access(bmsi_pkg::ACT_CPU_WRITE, 16'hE000, 8'h00);
        run_random(110);

        program_windows(8'hFF, 8'h00, 8'h00, 8'hFF);
        steady <= 1'b1;
        run_random(110);
        steady <= 1'b0;

        program_windows(8'h00, 8'hFF, 8'hFF, 8'h00);
        run_random(110);

        program_windows(pick_byte(), pick_byte(), pick_byte(), pick_byte());
        run_random(60);
        drain_results();
        run_random(60);

        drain_results();
        $display("covered %0d accesses: %0d cpu reads, %0d cpu writes, %0d ppu fetches, %0d unused",
                 items_sent, n_by_action[bmsi_pkg::ACT_CPU_READ],
                 n_by_action[bmsi_pkg::ACT_CPU_WRITE],
                 n_by_action[bmsi_pkg::ACT_PPU_FETCH], n_by_action[ACT_UNUSED]);
        $display("four bank window settings, %0d results compared, %0d with irq high",
                 results_checked, irq_results);
        if (fail_count == 0)
            $display("PASS bank_mapper_with_scanline_irq_core");
        else
            $display("FAIL bank_mapper_with_scanline_irq_core");
        $finish;
    end

endmodule
